@@ sv/tofhist_pkg.sv @@
// Package: constants, types and codes shared by the TOF histogram block.
package tofhist_pkg;

   localparam int BINS_PER_AXIS = 100;
   localparam int HALF_RANGE_MM = 500;
   localparam int COUNT_WIDTH   = 32;
   localparam int POS_FRAC_BITS = 4;

   localparam int OPC_W       = 1;
   localparam int POS_W       = 18;
   localparam int TIME_W      = 40;
   localparam int BIN_FIELD_W = 7;
   localparam int OUT_COUNT_W = 32;

   localparam int HIST_DEPTH = BINS_PER_AXIS * BINS_PER_AXIS;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int BIN_W      = $clog2(BINS_PER_AXIS);

   localparam int RANGE     = HALF_RANGE_MM * (2 ** POS_FRAC_BITS);
   localparam int SPAN      = 2 * RANGE;
   localparam int SPAN_W    = $clog2(SPAN);
   localparam int BPROD_W   = $clog2(SPAN * BINS_PER_AXIS);
   localparam int RECIP_SH  = BPROD_W + SPAN_W + 1;
   localparam int RECIP_W   = RECIP_SH - SPAN_W + 2;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + SPAN - 1) / SPAN;

   localparam int MD_W      = POS_W + 1;
   localparam int S_W       = 2 * MD_W;
   localparam int SQ_SH     = 24;
   localparam int RAD_W     = S_W + SQ_SH;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int SQRT_ITERS = ROOT_W;
   localparam int U_SH      = 32;
   localparam int N_W       = MD_W + U_SH;
   localparam int U_W       = 21;
   localparam int DIV_ITERS = U_W;
   localparam int ADT_SPLIT = TIME_W / 2;
   localparam int A_W       = U_W + TIME_W;
   localparam int HCQ_W     = 30;
   localparam logic [HCQ_W-1:0] HALF_C_Q = 30'd643799401;
   localparam int P_W       = A_W + HCQ_W;
   localparam int OFF_SH    = 44 - POS_FRAC_BITS;
   localparam int O_W       = P_W - OFF_SH;
   localparam int TOT_W     = O_W + 2;
   localparam int MID_SH    = 7;
   localparam int PT_SH     = 8;
   localparam int PT_W      = TOT_W - PT_SH;
   localparam int MUL_W     = 32;
   localparam int CNT_W     = $clog2(SQRT_ITERS);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV,
      ST_MA0, ST_MA1, ST_MB0, ST_MB1, ST_SUM, ST_BIN_MUL, ST_BIN_DIV, ST_BIN_IDX,
      ST_RD_IDX, ST_RAM_RD, ST_RAM_WR, ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_CLEAR, DP_SQ, DP_SQRT_INIT, DP_SQRT_STEP, DP_DIV_INIT,
      DP_DIV_STEP, DP_MUL_A0, DP_MUL_A1, DP_MUL_B0, DP_MUL_B1, DP_SUM, DP_BIN_MUL,
      DP_BIN_DIV, DP_BIN_IDX, DP_RD_IDX, DP_RAM_RD, DP_RAM_WR, DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic clear_last;
   } status_type;

endpackage

@@ sv/tofhist_if.sv @@
// Interfaces: request and response channels of the TOF histogram block.
interface tofhist_req_if;
   import tofhist_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [OPC_W-1:0]              opcode;
   logic [TIME_W-1:0]             hit_time;
   logic signed [POS_W-1:0]       pos_x;
   logic signed [POS_W-1:0]       pos_y;
   logic signed [POS_W-1:0]       pos_z;
   logic [BIN_FIELD_W-1:0]        read_bin_x;
   logic [BIN_FIELD_W-1:0]        read_bin_z;
   modport source (output valid, opcode, hit_time, pos_x, pos_y, pos_z, read_bin_x,
                   read_bin_z, input ready);
   modport sink (input valid, opcode, hit_time, pos_x, pos_y, pos_z, read_bin_x,
                 read_bin_z, output ready);
endinterface

interface tofhist_rsp_if;
   import tofhist_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [POS_W-1:0]       point_x;
   logic signed [POS_W-1:0]       point_y;
   logic signed [POS_W-1:0]       point_z;
   logic                          in_range;
   logic [OUT_COUNT_W-1:0]        bin_count;
   modport source (output valid, point_x, point_y, point_z, in_range, bin_count,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, in_range, bin_count,
                 output ready);
endinterface

@@ sv/tof_annihilation_point_histogram_top.sv @@
// Top level: TOF annihilation point reconstruction with X/Z histogram.
//
// req_ch carries one beat per hit (opcode 0) or per bin read (opcode 1).
// rsp_ch returns exactly one beat per request, in order.
// A hit beat passes through three squares on the shared multiplier, a 31-step
// square root, then per axis a 21-step divide and four multiplier passes,
// then binning and a histogram read-modify-write.
// A bin read goes through decode, index, RAM read and output load.
// One request is in flight at a time; req_ch.ready is high only when the
// block is free. The response sits in an output register, so a new request
// is taken while an earlier response waits; the block holds its last step
// until rsp_ch.ready frees the register.
// After reset the histogram RAM is swept to zero, one entry per cycle, over all
// 10000 entries; req_ch.ready stays low during the sweep. Reset also sets the
// previous hit to the origin at time zero.
module tof_annihilation_point_histogram_top (
   input  logic        clock,
   input  logic        reset,
   tofhist_req_if.sink   req_ch,
   tofhist_rsp_if.source rsp_ch
);
   import tofhist_pkg::*;

   cmd_type    cmd;
   status_type status;

   tofhist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   tofhist_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_ch.opcode),
      .req_hit_time   (req_ch.hit_time),
      .req_pos_x      (req_ch.pos_x),
      .req_pos_y      (req_ch.pos_y),
      .req_pos_z      (req_ch.pos_z),
      .req_read_bin_x (req_ch.read_bin_x),
      .req_read_bin_z (req_ch.read_bin_z),
      .status         (status),
      .rsp_point_x    (rsp_ch.point_x),
      .rsp_point_y    (rsp_ch.point_y),
      .rsp_point_z    (rsp_ch.point_z),
      .rsp_in_range   (rsp_ch.in_range),
      .rsp_bin_count  (rsp_ch.bin_count)
   );
endmodule

@@ sv/tofhist_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tofhist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/tofhist_ctrl.sv @@
// Controller: sequences the datapath through one beat and owns response valid.
module tofhist_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    rsp_ready,
   input  tofhist_pkg::status_type status,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output tofhist_pkg::cmd_type    cmd
);
   import tofhist_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       axis_ff, axis_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_DECODE;
         ST_DECODE:    state_in = status.is_read ? ST_RD_IDX : ST_SQ;
         ST_SQ:        if (cnt_ff == CNT_W'(2)) state_in = ST_SQRT_INIT;
         ST_SQRT_INIT: state_in = ST_SQRT;
         ST_SQRT:      if (cnt_ff == CNT_W'(SQRT_ITERS - 1)) state_in = ST_DIV_INIT;
         ST_DIV_INIT:  state_in = ST_DIV;
         ST_DIV:       if (cnt_ff == CNT_W'(DIV_ITERS - 1)) state_in = ST_MA0;
         ST_MA0:       state_in = ST_MA1;
         ST_MA1:       state_in = ST_MB0;
         ST_MB0:       state_in = ST_MB1;
         ST_MB1:       state_in = ST_SUM;
         ST_SUM:       state_in = (axis_ff == 2'd2) ? ST_BIN_MUL : ST_DIV_INIT;
         ST_BIN_MUL:   state_in = ST_BIN_DIV;
         ST_BIN_DIV:   state_in = ST_BIN_IDX;
         ST_BIN_IDX:   state_in = ST_RAM_RD;
         ST_RD_IDX:    state_in = ST_RAM_RD;
         ST_RAM_RD:    state_in = status.is_read ? ST_FINISH : ST_RAM_WR;
         ST_RAM_WR:    state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op   = DP_NOP;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_CLEAR:     cmd.op = DP_CLEAR;
         ST_IDLE:      if (req_valid) cmd.op = DP_LOAD;
         ST_DECODE:    cmd.op = DP_NOP;
         ST_SQ: begin
            cmd.op   = DP_SQ;
            cmd.axis = cnt_ff[1:0];
         end
         ST_SQRT_INIT: cmd.op = DP_SQRT_INIT;
         ST_SQRT:      cmd.op = DP_SQRT_STEP;
         ST_DIV_INIT:  cmd.op = DP_DIV_INIT;
         ST_DIV:       cmd.op = DP_DIV_STEP;
         ST_MA0:       cmd.op = DP_MUL_A0;
         ST_MA1:       cmd.op = DP_MUL_A1;
         ST_MB0:       cmd.op = DP_MUL_B0;
         ST_MB1:       cmd.op = DP_MUL_B1;
         ST_SUM:       cmd.op = DP_SUM;
         ST_BIN_MUL:   cmd.op = DP_BIN_MUL;
         ST_BIN_DIV:   cmd.op = DP_BIN_DIV;
         ST_BIN_IDX:   cmd.op = DP_BIN_IDX;
         ST_RD_IDX:    cmd.op = DP_RD_IDX;
         ST_RAM_RD:    cmd.op = DP_RAM_RD;
         ST_RAM_WR:    cmd.op = DP_RAM_WR;
         ST_FINISH:    if (out_free) cmd.op = DP_FINISH;
         default:      cmd.op = DP_NOP;
      endcase
   end

   always_comb begin
      cnt_in  = (state_in != state_ff) ? '0 : cnt_ff + CNT_W'(1);
      axis_in = axis_ff;
      if (state_ff == ST_IDLE) begin
         axis_in = 2'd0;
      end else if (state_ff == ST_SUM) begin
         axis_in = axis_ff + 2'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

@@ sv/tofhist_dp.sv @@
// Datapath: shared multiplier, square root and divider steps, binning and histogram RAM.
module tofhist_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tofhist_pkg::cmd_type                    cmd,
   input  logic [tofhist_pkg::OPC_W-1:0]           req_opcode,
   input  logic [tofhist_pkg::TIME_W-1:0]          req_hit_time,
   input  logic signed [tofhist_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [tofhist_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [tofhist_pkg::POS_W-1:0]    req_pos_z,
   input  logic [tofhist_pkg::BIN_FIELD_W-1:0]     req_read_bin_x,
   input  logic [tofhist_pkg::BIN_FIELD_W-1:0]     req_read_bin_z,
   output tofhist_pkg::status_type                 status,
   output logic signed [tofhist_pkg::POS_W-1:0]    rsp_point_x,
   output logic signed [tofhist_pkg::POS_W-1:0]    rsp_point_y,
   output logic signed [tofhist_pkg::POS_W-1:0]    rsp_point_z,
   output logic                                    rsp_in_range,
   output logic [tofhist_pkg::OUT_COUNT_W-1:0]     rsp_bin_count
);
   import tofhist_pkg::*;

   localparam logic signed [PT_W-1:0]  PT_MAX = PT_W'((2 ** (POS_W - 1)) - 1);
   localparam logic signed [PT_W-1:0]  PT_MIN = -PT_W'(2 ** (POS_W - 1));
   localparam logic signed [PT_W-1:0]  PT_RLO = -PT_W'(RANGE);
   localparam logic signed [PT_W-1:0]  PT_RHI = PT_W'(RANGE);
   localparam int MR_W = BPROD_W + RECIP_W;

   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [PT_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > PT_MAX) begin
         r = PT_MAX[POS_W-1:0];
      end else if (v < PT_MIN) begin
         r = PT_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   logic [OPC_W-1:0]          opcode_ff, opcode_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic [TIME_W-1:0]         prevt_ff, prevt_in;
   logic signed [POS_W-1:0]   pos_ff [3];
   logic signed [POS_W-1:0]   pos_in [3];
   logic signed [POS_W-1:0]   prev_ff [3];
   logic signed [POS_W-1:0]   prev_in [3];
   logic [BIN_FIELD_W-1:0]    rbx_ff, rbx_in, rbz_ff, rbz_in;
   logic [S_W-1:0]            s_ff, s_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [ROOT_W:0]           srem_ff, srem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [ROOT_W-1:0]         drem_ff, drem_in;
   logic [U_W-1:0]            dlow_ff, dlow_in;
   logic [U_W-1:0]            q_ff, q_in;
   logic [A_W-1:0]            a_ff, a_in;
   logic [P_W-1:0]            p_ff, p_in;
   logic signed [PT_W-1:0]    pt_ff [3];
   logic signed [PT_W-1:0]    pt_in [3];
   logic [BPROD_W-1:0]        mx_ff, mx_in, mz_ff, mz_in;
   logic [BIN_W-1:0]          bx_ff, bx_in, bz_ff, bz_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic                      ok_ff, ok_in;
   logic [COUNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic signed [POS_W-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                      inr_ff, inr_in;
   logic [OUT_COUNT_W-1:0]    bc_ff, bc_in;

   logic signed [MD_W-1:0]    d [3];
   logic [MD_W-1:0]           md [3];
   logic signed [MD_W-1:0]    mid [3];
   logic signed [TIME_W:0]    dt;
   logic                      dt_neg;
   logic [TIME_W-1:0]         adt;
   logic [U_W-1:0]            u;
   logic [MUL_W-1:0]          mul_a, mul_b;
   logic [2*MUL_W-1:0]        prod;
   logic [ROOT_W+2:0]         sq_x, sq_t;
   logic [ROOT_W:0]           dv_x;
   logic [N_W-1:0]            numer;
   logic [O_W-1:0]            off;
   logic signed [TOT_W-1:0]   tot;
   logic [SPAN_W-1:0]         vx, vz;
   logic [MR_W-1:0]           rx, rz;
   logic                      ram_we, ram_re;
   logic [ADDR_W-1:0]         ram_waddr;
   logic [COUNT_WIDTH-1:0]    ram_wdata, ram_rdata, inc;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d[i]   = MD_W'(pos_ff[i]) - MD_W'(prev_ff[i]);
         md[i]  = d[i][MD_W-1] ? MD_W'(-d[i]) : MD_W'(d[i]);
         mid[i] = MD_W'(pos_ff[i]) + MD_W'(prev_ff[i]);
      end
      dt     = $signed({1'b0, time_ff}) - $signed({1'b0, prevt_ff});
      dt_neg = dt[TIME_W];
      adt    = dt_neg ? TIME_W'(-dt) : TIME_W'(dt);
      u      = (root_ff == '0) ? '0 : q_ff;
      sq_x   = {srem_ff, rad_ff[RAD_W-1 -: 2]};
      sq_t   = {1'b0, root_ff, 2'b01};
      dv_x   = {drem_ff, dlow_ff[U_W-1]};
      numer  = {md[cmd.axis], U_SH'(0)} + N_W'(root_ff >> 1);
      off    = p_ff[P_W-1:OFF_SH];
      tot    = (TOT_W'(mid[cmd.axis]) <<< MID_SH)
             + (((d[cmd.axis][MD_W-1] ^ dt_neg) != 1'b0) ? -TOT_W'(off) : TOT_W'(off))
             + TOT_W'(2 ** (PT_SH - 1));
      vx     = SPAN_W'(pt_ff[0] - PT_RLO);
      vz     = SPAN_W'(pt_ff[2] - PT_RLO);
      rx     = MR_W'(mx_ff) * MR_W'(RECIP);
      rz     = MR_W'(mz_ff) * MR_W'(RECIP);
      inc    = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         DP_SQ: begin
            mul_a = MUL_W'(md[cmd.axis]);
            mul_b = MUL_W'(md[cmd.axis]);
         end
         DP_MUL_A0: begin
            mul_a = MUL_W'(u);
            mul_b = MUL_W'(adt[ADT_SPLIT-1:0]);
         end
         DP_MUL_A1: begin
            mul_a = MUL_W'(u);
            mul_b = MUL_W'(adt[TIME_W-1:ADT_SPLIT]);
         end
         DP_MUL_B0: begin
            mul_a = a_ff[MUL_W-1:0];
            mul_b = MUL_W'(HALF_C_Q);
         end
         DP_MUL_B1: begin
            mul_a = MUL_W'(a_ff[A_W-1:MUL_W]);
            mul_b = MUL_W'(HALF_C_Q);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      opcode_in = opcode_ff;
      time_in   = time_ff;
      prevt_in  = prevt_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      rbx_in    = rbx_ff;
      rbz_in    = rbz_ff;
      s_in      = s_ff;
      rad_in    = rad_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      drem_in   = drem_ff;
      dlow_in   = dlow_ff;
      q_in      = q_ff;
      a_in      = a_ff;
      p_in      = p_ff;
      pt_in     = pt_ff;
      mx_in     = mx_ff;
      mz_in     = mz_ff;
      bx_in     = bx_ff;
      bz_in     = bz_ff;
      idx_in    = idx_ff;
      ok_in     = ok_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pz_in     = pz_ff;
      inr_in    = inr_ff;
      bc_in     = bc_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = inc;
      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         DP_LOAD: begin
            opcode_in = req_opcode;
            time_in   = req_hit_time;
            pos_in[0] = req_pos_x;
            pos_in[1] = req_pos_y;
            pos_in[2] = req_pos_z;
            rbx_in    = req_read_bin_x;
            rbz_in    = req_read_bin_z;
         end
         DP_SQ: begin
            s_in = ((cmd.axis == 2'd0) ? S_W'(0) : s_ff) + S_W'(prod);
         end
         DP_SQRT_INIT: begin
            rad_in  = RAD_W'(s_ff) << SQ_SH;
            srem_in = '0;
            root_in = '0;
         end
         DP_SQRT_STEP: begin
            rad_in = rad_ff << 2;
            if (sq_x >= sq_t) begin
               srem_in = (ROOT_W + 1)'(sq_x - sq_t);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = (ROOT_W + 1)'(sq_x);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         DP_DIV_INIT: begin
            drem_in = ROOT_W'(numer[N_W-1:U_W]);
            dlow_in = numer[U_W-1:0];
            q_in    = '0;
         end
         DP_DIV_STEP: begin
            dlow_in = dlow_ff << 1;
            if (dv_x >= {1'b0, root_ff}) begin
               drem_in = ROOT_W'(dv_x - {1'b0, root_ff});
               q_in    = {q_ff[U_W-2:0], 1'b1};
            end else begin
               drem_in = ROOT_W'(dv_x);
               q_in    = {q_ff[U_W-2:0], 1'b0};
            end
         end
         DP_MUL_A0: a_in = A_W'(prod);
         DP_MUL_A1: a_in = a_ff + (A_W'(prod) << ADT_SPLIT);
         DP_MUL_B0: p_in = P_W'(prod) + (P_W'(1) << (OFF_SH - 1));
         DP_MUL_B1: p_in = p_ff + (P_W'(prod) << MUL_W);
         DP_SUM:    pt_in[cmd.axis] = PT_W'(tot >>> PT_SH);
         DP_BIN_MUL: begin
            ok_in = (pt_ff[0] >= PT_RLO) && (pt_ff[0] < PT_RHI)
                 && (pt_ff[2] >= PT_RLO) && (pt_ff[2] < PT_RHI);
            mx_in = BPROD_W'(vx * BINS_PER_AXIS);
            mz_in = BPROD_W'(vz * BINS_PER_AXIS);
         end
         DP_BIN_DIV: begin
            bx_in = BIN_W'(rx >> RECIP_SH);
            bz_in = BIN_W'(rz >> RECIP_SH);
         end
         DP_BIN_IDX: idx_in = ADDR_W'(bx_ff * BINS_PER_AXIS + bz_ff);
         DP_RD_IDX: begin
            ok_in  = (rbx_ff < BINS_PER_AXIS) && (rbz_ff < BINS_PER_AXIS);
            idx_in = ADDR_W'(rbx_ff * BINS_PER_AXIS + rbz_ff);
         end
         DP_RAM_RD: ram_re = 1'b1;
         DP_RAM_WR: begin
            ram_we = ok_ff;
            cnt_in = ok_ff ? inc : '0;
         end
         DP_FINISH: begin
            if (opcode_ff[0]) begin
               px_in  = '0;
               py_in  = '0;
               pz_in  = '0;
               inr_in = 1'b0;
               bc_in  = ok_ff ? OUT_COUNT_W'(ram_rdata) : '0;
            end else begin
               px_in    = clamp_pos(pt_ff[0]);
               py_in    = clamp_pos(pt_ff[1]);
               pz_in    = clamp_pos(pt_ff[2]);
               inr_in   = ok_ff;
               bc_in    = OUT_COUNT_W'(cnt_ff);
               prevt_in = time_ff;
               prev_in  = pos_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prevt_ff <= '0;
         prev_ff  <= '{default: '0};
         clr_ff   <= '0;
      end else begin
         prevt_ff <= prevt_in;
         prev_ff  <= prev_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      time_ff   <= time_in;
      pos_ff    <= pos_in;
      rbx_ff    <= rbx_in;
      rbz_ff    <= rbz_in;
      s_ff      <= s_in;
      rad_ff    <= rad_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      drem_ff   <= drem_in;
      dlow_ff   <= dlow_in;
      q_ff      <= q_in;
      a_ff      <= a_in;
      p_ff      <= p_in;
      pt_ff     <= pt_in;
      mx_ff     <= mx_in;
      mz_ff     <= mz_in;
      bx_ff     <= bx_in;
      bz_ff     <= bz_in;
      idx_ff    <= idx_in;
      ok_ff     <= ok_in;
      cnt_ff    <= cnt_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      inr_ff    <= inr_in;
      bc_ff     <= bc_in;
   end

   tofhist_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (HIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign status.is_read    = opcode_ff[0];
   assign status.clear_last = (clr_ff == ADDR_W'(HIST_DEPTH - 1));
   assign rsp_point_x       = px_ff;
   assign rsp_point_y       = py_ff;
   assign rsp_point_z       = pz_ff;
   assign rsp_in_range      = inr_ff;
   assign rsp_bin_count     = bc_ff;
endmodule

@@ sv/tofhist_checker.sv @@
// Checker: port-level properties of the TOF histogram block, bound to the top level.
module tofhist_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [tofhist_pkg::POS_W-1:0] point_x,
   input logic signed [tofhist_pkg::POS_W-1:0] point_z,
   input logic                                 in_range,
   input logic [tofhist_pkg::OUT_COUNT_W-1:0]  bin_count
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_range |-> bin_count != '0)
      else $error("counted point reports empty bin");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_range && (point_x != '0 || point_z != '0) |-> bin_count == '0)
      else $error("point outside area reports a count");
endmodule

bind tof_annihilation_point_histogram_top tofhist_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .point_x   (rsp_ch.point_x),
   .point_z   (rsp_ch.point_z),
   .in_range  (rsp_ch.in_range),
   .bin_count (rsp_ch.bin_count)
);

@@ test/tb_tof_annihilation_point_histogram_top.sv @@
// Testbench: random and directed hits and bin reads, checked against a built-in predictor.
module tb_tof_annihilation_point_histogram_top;
   import tofhist_pkg::*;

   localparam longint CYCLE_LIMIT = 2000000;
   localparam int     DRAIN_CYCLES = 200;
   localparam logic [OPC_W-1:0] OPC_HIT = 1'b0;
   localparam logic [OPC_W-1:0] OPC_READ = 1'b1;

   typedef struct {
      logic [OPC_W-1:0]        opcode;
      logic [TIME_W-1:0]       hit_time;
      logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
      logic [BIN_FIELD_W-1:0]  bin_x, bin_z;
   } hit_beat_type;

   typedef struct {
      logic signed [POS_W-1:0] x, y, z;
      logic                    in_range;
      logic [OUT_COUNT_W-1:0]  count;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   tofhist_req_if req_ch ();
   tofhist_rsp_if rsp_ch ();

   tof_annihilation_point_histogram_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always #4 clock = ~clock;

   hit_beat_type pending_beats[$];
   point_type    expected_points[$];
   logic [TIME_W-1:0] last_time;
   longint      last_pos[3];
   longint unsigned bin_counts[HIST_DEPTH];
   longint      cycle_count = 0;
   int          error_count = 0;
   int          hit_total = 0, read_total = 0, counted_total = 0, checked_total = 0;
   bit          beat_taken = 0;
   bit          calm;
   logic [TIME_W-1:0] gen_time = 40'd10000;

   // advance the generator clock, sometimes backwards
   function automatic logic [TIME_W-1:0] last_gen_time(int n);
      if ($urandom_range(19) == 0 && gen_time > 5000)
         gen_time -= TIME_W'($urandom_range(3000));
      else
         gen_time += TIME_W'($urandom_range(4000));
      return gen_time;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   function automatic point_type locate_annihilation(hit_beat_type b);
      point_type p;
      longint pos[3], d[3], pt[3], dt, off, total;
      longint unsigned s, r, adt, md, u, o;
      logic [127:0] prod;
      longint rng, bx, bz;
      p.x = '0; p.y = '0; p.z = '0; p.in_range = 0; p.count = '0;
      if (b.opcode[0] == OPC_READ) begin
         if (b.bin_x < BINS_PER_AXIS && b.bin_z < BINS_PER_AXIS)
            p.count = OUT_COUNT_W'(bin_counts[b.bin_x * BINS_PER_AXIS + b.bin_z]);
         return p;
      end
      pos[0] = b.pos_x; pos[1] = b.pos_y; pos[2] = b.pos_z;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = pos[i] - last_pos[i];
         s += d[i] * d[i];
      end
      dt = longint'({24'b0, b.hit_time}) - longint'({24'b0, last_time});
      adt = dt < 0 ? -dt : dt;
      r = s != 0 ? int_sqrt(s << 24) : 0;
      for (int i = 0; i < 3; i++) begin
         off = 0;
         if (r != 0 && d[i] != 0 && adt != 0) begin
            md = d[i] < 0 ? -d[i] : d[i];
            u = ((md << 32) + (r >> 1)) / r;
            prod = {64'b0, u * adt} * {98'b0, HALF_C_Q}
                   + (128'd1 << (43 - POS_FRAC_BITS));
            o = 64'(prod >> (44 - POS_FRAC_BITS));
            off = ((d[i] < 0) != (dt < 0)) ? -longint'(o) : longint'(o);
         end
         total = (pos[i] + last_pos[i]) * 128 + off + 128;
         pt[i] = total >>> 8;
      end
      rng = RANGE;
      if (pt[0] >= -rng && pt[0] < rng && pt[2] >= -rng && pt[2] < rng) begin
         bx = (pt[0] + rng) * BINS_PER_AXIS / (2 * rng);
         bz = (pt[2] + rng) * BINS_PER_AXIS / (2 * rng);
         if (bin_counts[bx * BINS_PER_AXIS + bz] < (64'd1 << COUNT_WIDTH) - 1)
            bin_counts[bx * BINS_PER_AXIS + bz]++;
         p.count = OUT_COUNT_W'(bin_counts[bx * BINS_PER_AXIS + bz]);
         p.in_range = 1;
      end
      p.x = POS_W'(pt[0] > 131071 ? 131071 : pt[0] < -131072 ? -131072 : pt[0]);
      p.y = POS_W'(pt[1] > 131071 ? 131071 : pt[1] < -131072 ? -131072 : pt[1]);
      p.z = POS_W'(pt[2] > 131071 ? 131071 : pt[2] < -131072 ? -131072 : pt[2]);
      last_time = b.hit_time;
      for (int i = 0; i < 3; i++) last_pos[i] = pos[i];
      return p;
   endfunction

   task automatic push_hit(logic [TIME_W-1:0] t, longint x, longint y, longint z);
      hit_beat_type b;
      b.opcode = OPC_HIT; b.hit_time = t;
      b.pos_x = POS_W'(x); b.pos_y = POS_W'(y); b.pos_z = POS_W'(z);
      b.bin_x = BIN_FIELD_W'($urandom); b.bin_z = BIN_FIELD_W'($urandom);
      pending_beats.push_back(b);
   endtask

   task automatic push_read(int bx, int bz);
      hit_beat_type b;
      b.opcode = OPC_READ; b.hit_time = TIME_W'({$urandom, $urandom});
      b.pos_x = POS_W'($urandom); b.pos_y = POS_W'($urandom); b.pos_z = POS_W'($urandom);
      b.bin_x = BIN_FIELD_W'(bx); b.bin_z = BIN_FIELD_W'(bz);
      pending_beats.push_back(b);
   endtask

   // accept and predict
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_ch.valid && req_ch.ready) begin
         hit_beat_type b;
         b.opcode = req_ch.opcode; b.hit_time = req_ch.hit_time;
         b.pos_x = req_ch.pos_x; b.pos_y = req_ch.pos_y; b.pos_z = req_ch.pos_z;
         b.bin_x = req_ch.read_bin_x; b.bin_z = req_ch.read_bin_z;
         if (b.opcode[0] == OPC_READ) read_total++;
         else hit_total++;
         expected_points.push_back(locate_annihilation(b));
         beat_taken = 1;
      end
   end

   // check responses
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         point_type e;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected response x=%0d y=%0d z=%0d", $time,
                     rsp_ch.point_x, rsp_ch.point_y, rsp_ch.point_z);
            error_count++;
         end else begin
            e = expected_points.pop_front();
            checked_total++;
            if (e.in_range) counted_total++;
            if (rsp_ch.point_x !== e.x || rsp_ch.point_y !== e.y ||
                rsp_ch.point_z !== e.z || rsp_ch.in_range !== e.in_range ||
                rsp_ch.bin_count !== e.count) begin
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d in=%0b cnt=%0d",
                        $time, e.x, e.y, e.z, e.in_range, e.count);
               $display("%0t:          actual   x=%0d y=%0d z=%0d in=%0b cnt=%0d",
                        $time, rsp_ch.point_x, rsp_ch.point_y, rsp_ch.point_z,
                        rsp_ch.in_range, rsp_ch.bin_count);
               error_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // drive requests and response ready
   always @(negedge clock) begin
      calm = cycle_count > 60000 && cycle_count < 90000;
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || $urandom_range(99) >= 33;
         if (beat_taken || !req_ch.valid) begin
            beat_taken = 0;
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
               hit_beat_type b;
               b = pending_beats.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.opcode <= b.opcode; req_ch.hit_time <= b.hit_time;
               req_ch.pos_x <= b.pos_x; req_ch.pos_y <= b.pos_y; req_ch.pos_z <= b.pos_z;
               req_ch.read_bin_x <= b.bin_x; req_ch.read_bin_z <= b.bin_z;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      logic [TIME_W-1:0] t;
      int k;
      req_ch.valid = 0; req_ch.opcode = '0; req_ch.hit_time = '0;
      req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.pos_z = '0;
      req_ch.read_bin_x = '0; req_ch.read_bin_z = '0;
      rsp_ch.ready = 0;
      last_time = '0;
      for (int i = 0; i < 3; i++) last_pos[i] = 0;
      for (int i = 0; i < HIST_DEPTH; i++) bin_counts[i] = 0;

      push_read(0, 0);
      push_hit(40'd1000, 160, -80, 320);
      push_hit(40'd1500, 160, -80, 320);
      push_hit(40'd900, -400, 96, -200);
      push_hit(40'd900, 800, 0, 0);
      push_hit(40'd5000, 131071, 131071, 131071);
      push_hit(40'd0, -131072, -131072, -131072);
      push_hit(40'hFF_FFFF_FFFF, 131071, -131072, 0);
      push_hit(40'd0, 0, 0, 0);
      push_hit(40'd0, -8000, 0, -8000);
      push_hit(40'd0, 7999, 0, 7999);
      push_hit(40'd0, 8000, 0, 0);
      push_hit(40'd20, 0, 0, 0);
      push_read(50, 50);
      push_read(0, 0);
      push_read(99, 99);
      push_read(100, 3);
      push_read(127, 127);
      push_read(49, 50);
      for (int n = 0; n < 1950; n++) begin
         k = $urandom_range(99);
         if (k < 70) begin
            t = last_gen_time(n);
            push_hit(t, $signed($urandom_range(12000)) - 6000,
                     $signed($urandom_range(12000)) - 6000,
                     $signed($urandom_range(12000)) - 6000);
         end else if (k < 82) begin
            push_read($urandom_range(35, 64), $urandom_range(35, 64));
         end else if (k < 86) begin
            push_read($urandom_range(127), $urandom_range(127));
         end else begin
            push_hit(TIME_W'({$urandom, $urandom}), $signed(18'($urandom)),
                     $signed(18'($urandom)), $signed(18'($urandom)));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_beats.size() == 0 && !req_ch.valid);
      wait (expected_points.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d hits (%0d binned) and %0d bin reads, %0d responses checked",
               hit_total, counted_total, read_total, checked_total);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/tofhist_pkg.sv
sv/tofhist_if.sv
sv/tofhist_ram.sv
sv/tofhist_ctrl.sv
sv/tofhist_dp.sv
sv/tof_annihilation_point_histogram_top.sv
sv/tofhist_checker.sv
test/tb_tof_annihilation_point_histogram_top.sv
